// ===== sv/lds_pkg.sv =====
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types, codes and helpers for the LED driver shift/latch serializer.
// ----------------------------------------------------------------------------
package lds_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_CHIPS_DEF       = 4;
  localparam int BYTES_PER_PIXEL_DEF = 16;

  // Fixed field widths
  localparam int KIND_W  = 3;
  localparam int PINS_W  = 6;
  localparam int WORD_W  = 16;
  localparam int LATCH_W = 5;
  localparam int BIT_W   = 4;
  localparam int CHIP_W  = 6;

  // Clocks in one chip slot, and the latch threshold that never fires
  localparam logic [LATCH_W-1:0] SLOT_CLOCKS = 5'd16;
  localparam logic [BIT_W-1:0]   LAST_BIT    = 4'd15;
  localparam logic [BIT_W-1:0]   CMD_LAST    = 4'd14;

  // Latch start positions for the commands; the latch is high from here to the final clock
  localparam logic [LATCH_W-1:0] PRE_LATCH_FROM   = 5'd1;
  localparam logic [LATCH_W-1:0] VSYNC_LATCH_FROM = 5'd12;
  localparam logic [LATCH_W-1:0] ON_LATCH_FROM    = 5'd3;
  localparam logic [LATCH_W-1:0] OFF_LATCH_FROM   = 5'd2;

  // Depth of the job queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL = 3'd0,
    KIND_REG   = 3'd1,
    KIND_PRE   = 3'd2,
    KIND_VSYNC = 3'd3,
    KIND_ON    = 3'd4,
    KIND_OFF   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    MODE_PIXEL = 2'd0,
    MODE_REG   = 2'd1,
    MODE_CMD   = 2'd2
  } mode_t;

  // One resolved burst of clocks for the back end
  typedef struct packed {
    mode_t               mode;
    logic [PINS_W-1:0]   pins;        // pixel first clock, or held pins
    logic [WORD_W-1:0]   red;
    logic [WORD_W-1:0]   green;
    logic [WORD_W-1:0]   blue;
    logic [BIT_W-1:0]    start;       // first clock position
    logic [BIT_W-1:0]    stop;        // final clock position
    logic [LATCH_W-1:0]  latch_from;  // latch high at positions >= this
  } job_t;

  // Register bit to pins: red 0x09, green 0x12, blue 0x24
  function automatic logic [PINS_W-1:0] reg_pins(input logic r, input logic g,
                                                 input logic b);
    return {b, g, r, b, g, r};
  endfunction

endpackage

// ===== sv/lds_if.sv =====
// ----------------------------------------------------------------------------
// lds_in_if / lds_out_if
// Valid/ready channels for input items and for output clock words.
// ----------------------------------------------------------------------------
interface lds_in_if
  import lds_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [PINS_W-1:0]   pixel_pins;
  logic [WORD_W-1:0]   reg_red;
  logic [WORD_W-1:0]   reg_green;
  logic [WORD_W-1:0]   reg_blue;
  logic [LATCH_W-1:0]  latch_clocks;

  modport source (output valid, kind, pixel_pins, reg_red, reg_green, reg_blue,
                  latch_clocks, input ready);
  modport sink   (input valid, kind, pixel_pins, reg_red, reg_green, reg_blue,
                  latch_clocks, output ready);
endinterface

interface lds_out_if
  import lds_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [PINS_W-1:0] rgb_pins;
  logic              latch_level;
  logic              last;

  modport source (output valid, rgb_pins, latch_level, last, input ready);
  modport sink   (input valid, rgb_pins, latch_level, last, output ready);
endinterface

// ===== sv/lds_front.sv =====
// ----------------------------------------------------------------------------
// lds_front
// Classifies input items, tracks bit/chip/held-pin state and emits jobs.
// ----------------------------------------------------------------------------
module lds_front
  import lds_pkg::*;
#(
  parameter int NUM_CHIPS       = NUM_CHIPS_DEF,
  parameter int BYTES_PER_PIXEL = BYTES_PER_PIXEL_DEF
) (
  input  logic      clk,
  input  logic      rst,
  lds_in_if.sink    in_ch,
  output logic      push,
  output job_t      job,
  input  logic      q_ready
);

  logic [BIT_W-1:0]   bit_index, bit_index_next;
  logic [CHIP_W-1:0]  chip_index, chip_index_next;
  logic [PINS_W-1:0]  held_pins, held_pins_next;
  logic               last_chip;
  logic [CHIP_W-1:0]  chip_inc;
  logic [LATCH_W-1:0] bit_inc;
  logic [LATCH_W-1:0] lc_sat;
  logic               accept;
  logic               known;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && known;

  assign last_chip = (chip_index == CHIP_W'(NUM_CHIPS - 1));
  assign chip_inc  = last_chip ? '0 : chip_index + CHIP_W'(1);
  assign bit_inc   = {1'b0, bit_index} + LATCH_W'(1);
  assign lc_sat    = (in_ch.latch_clocks > SLOT_CLOCKS) ? SLOT_CLOCKS : in_ch.latch_clocks;

  // Resolve the item into a burst and the state it leaves behind
  always_comb begin
    known           = 1'b1;
    bit_index_next  = bit_index;
    chip_index_next = chip_index;
    held_pins_next  = held_pins;
    job.mode        = MODE_CMD;
    job.pins        = held_pins;
    job.red         = in_ch.reg_red;
    job.green       = in_ch.reg_green;
    job.blue        = in_ch.reg_blue;
    job.start       = '0;
    job.stop        = CMD_LAST;
    job.latch_from  = SLOT_CLOCKS;
    case (in_ch.kind)
      KIND_PIXEL: begin
        job.mode       = MODE_PIXEL;
        job.pins       = in_ch.pixel_pins;
        job.start      = bit_index;
        job.latch_from = last_chip ? {1'b0, LAST_BIT} : SLOT_CLOCKS;
        if (bit_inc >= LATCH_W'(BYTES_PER_PIXEL)) begin
          // pad to the end of the slot, then move to the next chip
          job.stop        = LAST_BIT;
          bit_index_next  = '0;
          chip_index_next = chip_inc;
          held_pins_next  = (bit_index == LAST_BIT) ? in_ch.pixel_pins : '0;
        end else begin
          job.stop       = bit_index;
          bit_index_next = bit_inc[BIT_W-1:0];
          held_pins_next = in_ch.pixel_pins;
        end
      end
      KIND_REG: begin
        job.mode        = MODE_REG;
        job.stop        = LAST_BIT;
        job.latch_from  = last_chip ? (SLOT_CLOCKS - lc_sat) : SLOT_CLOCKS;
        chip_index_next = chip_inc;
        held_pins_next  = reg_pins(in_ch.reg_red[0], in_ch.reg_green[0],
                                   in_ch.reg_blue[0]);
      end
      KIND_PRE:   job.latch_from = PRE_LATCH_FROM;
      KIND_VSYNC: job.latch_from = VSYNC_LATCH_FROM;
      KIND_ON:    job.latch_from = ON_LATCH_FROM;
      KIND_OFF:   job.latch_from = OFF_LATCH_FROM;
      default:    known = 1'b0;
    endcase
  end

  // Advance state on each queued job
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_index  <= '0;
      chip_index <= '0;
      held_pins  <= '0;
    end else if (push) begin
      bit_index  <= bit_index_next;
      chip_index <= chip_index_next;
      held_pins  <= held_pins_next;
    end
  end

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, bit_index} < LATCH_W'(BYTES_PER_PIXEL))
    else $error("bit_index past pixel length");

  a_chip_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, chip_index} < (CHIP_W+1)'(NUM_CHIPS))
    else $error("chip_index past chain length");

endmodule

// ===== sv/lds_queue.sv =====
// ----------------------------------------------------------------------------
// lds_queue
// Short job queue that decouples the front end from the clock generator.
// ----------------------------------------------------------------------------
module lds_queue
  import lds_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic push_ready,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  job_t                entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  count;

  assign push_ready = (count != Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Store incoming job
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> push_ready)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ===== sv/lds_back.sv =====
// ----------------------------------------------------------------------------
// lds_back
// Expands the head job into registered shift clocks, one per unstalled cycle.
// ----------------------------------------------------------------------------
module lds_back
  import lds_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  job_t      head,
  output logic      pop,
  lds_out_if.source out_ch
);

  logic [BIT_W-1:0]  idx;
  logic              first;
  logic [BIT_W-1:0]  cur_idx;
  logic [BIT_W-1:0]  rev_idx;
  logic              load;
  logic              done;
  logic [PINS_W-1:0] pins_c;
  logic              latch_c;

  assign cur_idx = first ? head.start : idx;
  assign rev_idx = ~cur_idx;
  assign load    = head_valid && (!out_ch.valid || out_ch.ready);
  assign done    = (cur_idx == head.stop);
  assign pop     = load && done;
  assign latch_c = ({1'b0, cur_idx} >= head.latch_from);

  // Select pin levels for this clock
  always_comb begin
    case (head.mode)
      MODE_REG:   pins_c = reg_pins(head.red[rev_idx], head.green[rev_idx],
                                    head.blue[rev_idx]);
      MODE_PIXEL: pins_c = first ? head.pins : '0;
      default:    pins_c = head.pins;
    endcase
  end

  // Walk the position counter through the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b1;
      idx   <= '0;
    end else if (load) begin
      first <= done;
      idx   <= cur_idx + BIT_W'(1);
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.rgb_pins    <= pins_c;
      out_ch.latch_level <= latch_c;
      out_ch.last        <= done;
    end
  end

  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_ch.valid && out_ch.last)
    else $error("job retired without a final clock");

  a_mid_job: assert property (@(posedge clk) disable iff (rst)
    (load && !done) |=> !first && out_ch.valid && !out_ch.last)
    else $error("job position lost mid-burst");

endmodule

// ===== sv/led_driver_shift_latch_serializer.sv =====
// ----------------------------------------------------------------------------
// led_driver_shift_latch_serializer
// Turns pixel, register and command items into clock words for a chain of
// shift-and-latch LED driver chips.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per accepted word: a pixel byte, a register word
//   triple, or one of the pre-active, vsync, display on/off commands. out_ch
//   carries one word per panel clock: six pin levels, the latch level and a
//   last flag on the final clock of each item.
//   A pixel item gives one clock, plus zero padding clocks to the end of the
//   chip slot after the final byte; a register item fills the whole chip slot; a
//   command runs to position CMD_LAST. Unknown kinds are taken and dropped.
//   The first clock of an item passes through the job queue and the output
//   register before it appears on out_ch. The clock generator emits one word
//   per cycle while out_ch takes every word, so pixel bytes without padding
//   sustain one item per cycle; longer items occupy it until their last clock.
//   A two-entry job queue takes the next item while the current burst is sent.
//   Reset clears the bit, chip and held-pin state and empties the queue.
//   When out_ch stalls the word is held, the queue fills and in_ch.ready
//   drops once it is full.
// ----------------------------------------------------------------------------
module led_driver_shift_latch_serializer
  import lds_pkg::*;
#(
  parameter int NUM_CHIPS       = NUM_CHIPS_DEF,
  parameter int BYTES_PER_PIXEL = BYTES_PER_PIXEL_DEF
) (
  input  logic      clk,
  input  logic      rst,
  lds_in_if.sink    in_ch,
  lds_out_if.source out_ch
);

  logic push;
  logic q_ready;
  job_t job;
  logic pop;
  logic head_valid;
  job_t head;

  lds_front #(
    .NUM_CHIPS       (NUM_CHIPS),
    .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .push    (push),
    .job     (job),
    .q_ready (q_ready)
  );

  lds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (job),
    .push_ready (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  lds_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== verif/tb_led_driver_shift_latch_serializer.sv =====
// ----------------------------------------------------------------------------
// tb_led_driver_shift_latch_serializer
// Self-checking bench for the LED driver shift/latch serializer. A short
// stimulus table covers every item kind, the pin and latch extremes, latch
// count saturation and the ignored kind codes. Random pixel slots, register
// writes across the chip chain, commands and noise follow. Every clock word
// from the block is checked against a fixed table row or a cycle-free chain model.
// Both channels idle at random, and one long output stall backs up the input.
// ----------------------------------------------------------------------------
module tb_led_driver_shift_latch_serializer
  import lds_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_CHIPS   = NUM_CHIPS_DEF;
  localparam int PIX_BYTES = BYTES_PER_PIXEL_DEF;

  // Panel timing constants
  localparam int SLOT_LEN   = 16;
  localparam int CMD_LEN    = 15;
  localparam int PRE_HIGH   = 14;
  localparam int VSYNC_HIGH = 3;
  localparam int ON_HIGH    = 12;
  localparam int OFF_HIGH   = 13;

  // Pin groups driven by one register bit per color
  localparam logic [PINS_W-1:0] RED_PINS   = 6'h09;
  localparam logic [PINS_W-1:0] GREEN_PINS = 6'h12;
  localparam logic [PINS_W-1:0] BLUE_PINS  = 6'h24;
  localparam logic [PINS_W-1:0] ALL_PINS   = 6'h3F;
  localparam logic [PINS_W-1:0] NO_PINS    = 6'h00;

  // Kind codes the block takes and drops
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [PINS_W-1:0]  pix;
    logic [WORD_W-1:0]  red;
    logic [WORD_W-1:0]  green;
    logic [WORD_W-1:0]  blue;
    logic [LATCH_W-1:0] lc;
  } panel_item_t;

  typedef struct {
    logic [PINS_W-1:0] pins;
    logic              latch;
    logic              last;
  } panel_clock_t;

  // One stimulus row; when fixed, the row replaces the model: field n gives the
  // length of the expected burst, pins its pin levels and lat_hi its latch-high tail
  typedef struct {
    panel_item_t       item;
    bit                fixed;
    int                n;
    logic [PINS_W-1:0] pins;
    int                lat_hi;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;

  lds_in_if  in_ch();
  lds_out_if out_ch();

  led_driver_shift_latch_serializer #(
    .NUM_CHIPS      (N_CHIPS),
    .BYTES_PER_PIXEL(PIX_BYTES)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Model state of the chip chain
  logic [BIT_W-1:0]  pos_in_slot;
  logic [CHIP_W-1:0] cur_chip;
  logic [PINS_W-1:0] line_pins;

  panel_clock_t item_clocks[$];
  panel_clock_t clocks_due[$];
  step_row_t    step_rows[$];

  int errors        = 0;
  int words_checked = 0;
  int n_pixel       = 0;
  int n_reg         = 0;
  int n_cmd         = 0;
  int n_ignored     = 0;
  int src_idle_pct  = 0;
  int snk_idle_pct  = 0;
  bit hold_request  = 1'b0;
  int hold_left     = 0;

  function automatic panel_clock_t clk_word(input logic [PINS_W-1:0] pins,
                                            input logic lat);
    panel_clock_t w;
    w.pins  = pins;
    w.latch = lat;
    w.last  = 1'b0;
    return w;
  endfunction

  function automatic void step_chip();
    cur_chip = (cur_chip == CHIP_W'(N_CHIPS - 1)) ? '0 : cur_chip + CHIP_W'(1);
  endfunction

  // Work out the clock words one item produces, and advance the chain state
  function automatic void predict_panel_clocks(input panel_item_t it);
    logic              last_chip;
    logic [PINS_W-1:0] d;
    int                pos;
    int                lat_n;
    int                k;
    int                i;
    item_clocks = {};
    last_chip = (cur_chip == CHIP_W'(N_CHIPS - 1));
    case (it.kind)
      KIND_PIXEL: begin
        pos = pos_in_slot;
        item_clocks.push_back(clk_word(it.pix, last_chip && pos == SLOT_LEN - 1));
        pos++;
        // pad with zero pins to the end of the slot after the final byte
        if (pos >= PIX_BYTES) begin
          while (pos < SLOT_LEN) begin
            item_clocks.push_back(clk_word(NO_PINS, last_chip && pos == SLOT_LEN - 1));
            pos++;
          end
          pos = 0;
          step_chip();
        end
        pos_in_slot = BIT_W'(pos);
      end
      KIND_REG: begin
        lat_n = (int'(it.lc) > SLOT_LEN) ? SLOT_LEN : int'(it.lc);
        // shift MSB first, latch on the tail of the last chip's word
        for (i = 0; i < SLOT_LEN; i++) begin
          d = NO_PINS;
          if (it.red[SLOT_LEN-1-i])   d = d + RED_PINS;
          if (it.green[SLOT_LEN-1-i]) d = d + GREEN_PINS;
          if (it.blue[SLOT_LEN-1-i])  d = d + BLUE_PINS;
          item_clocks.push_back(clk_word(d, last_chip && i >= SLOT_LEN - lat_n));
        end
        step_chip();
      end
      KIND_PRE, KIND_VSYNC, KIND_ON, KIND_OFF: begin
        case (it.kind)
          KIND_PRE:   k = PRE_HIGH;
          KIND_VSYNC: k = VSYNC_HIGH;
          KIND_ON:    k = ON_HIGH;
          default:    k = OFF_HIGH;
        endcase
        for (i = 0; i < CMD_LEN; i++)
          item_clocks.push_back(clk_word(line_pins, i >= CMD_LEN - k));
      end
      default: ;
    endcase
    if (item_clocks.size() != 0) begin
      item_clocks[item_clocks.size()-1].last = 1'b1;
      line_pins = item_clocks[item_clocks.size()-1].pins;
    end
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return WORD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Random item of a given kind, with every field randomized
  function automatic panel_item_t rand_item(input logic [KIND_W-1:0] kind);
    panel_item_t it;
    it.kind  = kind;
    it.pix   = PINS_W'($urandom_range(0, 63));
    it.red   = rand_word();
    it.green = rand_word();
    it.blue  = rand_word();
    it.lc    = ($urandom_range(0, 3) == 0) ? LATCH_W'($urandom_range(17, 31))
                                           : LATCH_W'($urandom_range(0, 16));
    return it;
  endfunction

  function automatic void add_row(input logic [KIND_W-1:0] kind,
                                  input logic [PINS_W-1:0] pix,
                                  input logic [WORD_W-1:0] red,
                                  input logic [WORD_W-1:0] green,
                                  input logic [WORD_W-1:0] blue,
                                  input logic [LATCH_W-1:0] lc,
                                  input bit fixed, input int n,
                                  input logic [PINS_W-1:0] pins, input int lat_hi);
    step_row_t r;
    r.item.kind  = kind;
    r.item.pix   = pix;
    r.item.red   = red;
    r.item.green = green;
    r.item.blue  = blue;
    r.item.lc    = lc;
    r.fixed      = fixed;
    r.n          = n;
    r.pins       = pins;
    r.lat_hi     = lat_hi;
    step_rows.push_back(r);
  endfunction

  // Offer one word, wait for acceptance, then queue its expected clocks
  task automatic issue(input panel_item_t it, input bit fixed, input int n,
                       input logic [PINS_W-1:0] pins, input int lat_hi);
    int i;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= it.kind;
    in_ch.pixel_pins   <= it.pix;
    in_ch.reg_red      <= it.red;
    in_ch.reg_green    <= it.green;
    in_ch.reg_blue     <= it.blue;
    in_ch.latch_clocks <= it.lc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_panel_clocks(it);
    if (fixed) begin
      item_clocks = {};
      for (i = 0; i < n; i++)
        item_clocks.push_back(clk_word(pins, i >= n - lat_hi));
      if (n > 0) item_clocks[n-1].last = 1'b1;
    end
    foreach (item_clocks[i]) clocks_due.push_back(item_clocks[i]);
    case (it.kind)
      KIND_PIXEL:                            n_pixel++;
      KIND_REG:                              n_reg++;
      KIND_PRE, KIND_VSYNC, KIND_ON, KIND_OFF: n_cmd++;
      default:                               n_ignored++;
    endcase
  endtask

  // Drop valid and hold until every expected clock word has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (clocks_due.size() != 0) @(posedge clk);
  endtask

  // Mix of pixel runs and slots, full-chain register writes, commands and noise
  task automatic run_random(input int budget);
    int goal;
    int sel;
    int i;
    goal = n_pixel + n_reg + n_cmd + budget;
    while (n_pixel + n_reg + n_cmd < goal) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        // steer some slots onto the last chip so the pixel latch fires
        if ($urandom_range(0, 1) == 1)
          while (cur_chip != CHIP_W'(N_CHIPS - 1))
            issue(rand_item(KIND_REG), 1'b0, 0, NO_PINS, 0);
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 6)) issue(rand_item(KIND_PIXEL), 1'b0, 0, NO_PINS, 0);
        end else begin
          do issue(rand_item(KIND_PIXEL), 1'b0, 0, NO_PINS, 0);
          while (pos_in_slot != '0);
        end
      end else if (sel < 7) begin
        issue(rand_item(KIND_PRE), 1'b0, 0, NO_PINS, 0);
        for (i = 0; i < N_CHIPS; i++) issue(rand_item(KIND_REG), 1'b0, 0, NO_PINS, 0);
      end else if (sel < 9) begin
        issue(rand_item(KIND_W'($urandom_range(KIND_PRE, KIND_OFF))), 1'b0, 0, NO_PINS, 0);
      end else begin
        issue(rand_item(KIND_W'($urandom_range(0, 7))), 1'b0, 0, NO_PINS, 0);
      end
    end
  endtask

  // Compare one accepted clock word with the oldest expectation
  function automatic void check_clock_word();
    panel_clock_t want;
    if (clocks_due.size() == 0) begin
      $error("unexpected clock word: pins %02h latch %0b last %0b",
             out_ch.rgb_pins, out_ch.latch_level, out_ch.last);
      errors++;
      return;
    end
    want = clocks_due.pop_front();
    words_checked++;
    if (out_ch.rgb_pins !== want.pins) begin
      $error("rgb_pins: expected %02h, got %02h", want.pins, out_ch.rgb_pins);
      errors++;
    end
    if (out_ch.latch_level !== want.latch) begin
      $error("latch_level: expected %0b, got %0b", want.latch, out_ch.latch_level);
      errors++;
    end
    if (out_ch.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, out_ch.last);
      errors++;
    end
  endfunction

  // Output side: check accepted words, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) check_clock_word();
    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Stimulus
  initial begin
    int spin;
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.kind         = '0;
    in_ch.pixel_pins   = '0;
    in_ch.reg_red      = '0;
    in_ch.reg_green    = '0;
    in_ch.reg_blue     = '0;
    in_ch.latch_clocks = '0;
    out_ch.ready       = 1'b0;
    pos_in_slot        = '0;
    cur_chip           = '0;
    line_pins          = '0;

    // kind, pixel, red, green, blue, latch count, fixed, clocks, pins, latch high
    add_row(KIND_PRE,     6'h00, 16'h0000, 16'h0000, 16'h0000, 5'd0,  1, CMD_LEN, NO_PINS, PRE_HIGH);
    add_row(KIND_VSYNC,   6'h3F, 16'hFFFF, 16'h0000, 16'hFFFF, 5'd31, 1, CMD_LEN, NO_PINS, VSYNC_HIGH);
    add_row(KIND_ON,      6'h00, 16'h0000, 16'h0000, 16'h0000, 5'd0,  1, CMD_LEN, NO_PINS, ON_HIGH);
    add_row(KIND_OFF,     6'h00, 16'h0000, 16'h0000, 16'h0000, 5'd0,  1, CMD_LEN, NO_PINS, OFF_HIGH);
    add_row(KIND_SPARE_A, 6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 1, 0, NO_PINS, 0);
    add_row(KIND_SPARE_B, 6'h00, 16'h0000, 16'h0000, 16'h0000, 5'd0,  1, 0, NO_PINS, 0);
    add_row(KIND_PIXEL,   6'h3F, 16'h0000, 16'h0000, 16'h0000, 5'd0,  1, 1, ALL_PINS, 0);
    add_row(KIND_PRE,     6'h00, 16'h0000, 16'h0000, 16'h0000, 5'd0,  1, CMD_LEN, ALL_PINS, PRE_HIGH);
    add_row(KIND_PIXEL,   6'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 1, 1, NO_PINS, 0);
    add_row(KIND_REG,     6'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 1, SLOT_LEN, ALL_PINS, 0);
    add_row(KIND_REG,     6'h3F, 16'h0000, 16'h0000, 16'h0000, 5'd0,  1, SLOT_LEN, NO_PINS, 0);
    add_row(KIND_REG,     6'h00, 16'h8001, 16'h00FF, 16'hA5A5, 5'd5,  0, 0, NO_PINS, 0);
    add_row(KIND_REG,     6'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd16, 1, SLOT_LEN, ALL_PINS, SLOT_LEN);
    add_row(KIND_REG,     6'h00, 16'hFFFF, 16'h0000, 16'h0000, 5'd16, 1, SLOT_LEN, RED_PINS, 0);
    add_row(KIND_REG,     6'h00, 16'h0000, 16'hFFFF, 16'h0000, 5'd16, 1, SLOT_LEN, GREEN_PINS, 0);
    add_row(KIND_REG,     6'h00, 16'h0000, 16'h0000, 16'hFFFF, 5'd16, 1, SLOT_LEN, BLUE_PINS, 0);
    add_row(KIND_REG,     6'h3F, 16'h0000, 16'h0000, 16'h0000, 5'd31, 1, SLOT_LEN, NO_PINS, SLOT_LEN);
    add_row(KIND_OFF,     6'h3F, 16'h0000, 16'h0000, 16'h0000, 5'd0,  1, CMD_LEN, NO_PINS, OFF_HIGH);
    add_row(KIND_REG,     6'h00, 16'h1234, 16'hF00F, 16'h0F0F, 5'd1,  0, 0, NO_PINS, 0);
    add_row(KIND_REG,     6'h00, 16'h7FFF, 16'h8000, 16'h5555, 5'd17, 0, 0, NO_PINS, 0);
    add_row(KIND_REG,     6'h00, 16'hAAAA, 16'h5555, 16'hFFFE, 5'd15, 0, 0, NO_PINS, 0);
    add_row(KIND_REG,     6'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd0,  1, SLOT_LEN, ALL_PINS, 0);
    add_row(KIND_VSYNC,   6'h00, 16'h0000, 16'h0000, 16'h0000, 5'd0,  1, CMD_LEN, ALL_PINS, VSYNC_HIGH);
    add_row(KIND_PIXEL,   6'h2A, 16'h0000, 16'h0000, 16'h0000, 5'd0,  0, 0, NO_PINS, 0);
    add_row(KIND_PIXEL,   6'h15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 0, 0, NO_PINS, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table, then random items; sender idles lightly, receiver heavily
    src_idle_pct = 10;
    snk_idle_pct = 45;
    foreach (step_rows[i])
      issue(step_rows[i].item, step_rows[i].fixed, step_rows[i].n,
            step_rows[i].pins, step_rows[i].lat_hi);
    run_random(50);

    // Swap idling, after a full pause on the sender side
    drain();
    src_idle_pct = 45;
    snk_idle_pct = 10;
    run_random(60);

    // No idling; open with a long output stall so the input backs up
    drain();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_request = 1'b1;
    run_random(60);

    // Wait out the tail, then give stray words a chance to show
    in_ch.valid <= 1'b0;
    @(posedge clk);
    spin = 0;
    while (clocks_due.size() != 0 && spin < 50000) begin
      @(posedge clk);
      spin++;
    end
    repeat (20) @(posedge clk);
    if (clocks_due.size() != 0) begin
      $error("%0d expected clock words never arrived", clocks_due.size());
      errors++;
    end

    $display("Run covered %0d pixel, %0d register, %0d command and %0d dropped items;",
             n_pixel, n_reg, n_cmd, n_ignored);
    $display("%0d clock words checked across three idling mixes and one long stall.",
             words_checked);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lds_pkg.sv
sv/lds_if.sv
sv/lds_front.sv
sv/lds_queue.sv
sv/lds_back.sv
sv/led_driver_shift_latch_serializer.sv
verif/tb_led_driver_shift_latch_serializer.sv
